### design/int4_dequant_dot_product_top_macros.svh
// Assertion macros for the int4 dequant dot product block.
// Used by the controller and the datapath; needs clk and rst_n in scope.
`ifndef INT4_DEQUANT_DOT_PRODUCT_TOP_MACROS_SVH
`define INT4_DEQUANT_DOT_PRODUCT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define I4DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define I4DQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define I4DQ_ASSERT(lbl, prop, msg)
`define I4DQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/i4dq_pkg.sv
// Shared types, constants and fp32 helper functions for the int4 dequant block.
// No dependencies.
`timescale 1ns / 1ps

package i4dq_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ADD1,
    ST_ADD2,
    ST_SMUL1,
    ST_SMUL2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic mul1;
    logic mul_scale;
    logic mul2;
    logic add1;
    logic add2;
    logic out_load;
    logic acc_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic out_blocked;
  } status_t;

  // leading zero count of a 48-bit word (48 when zero)
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. m has its leading one at bit 47,
  // r is the biased exponent that leading one stands for.
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [11:0] r,
                                             input logic [47:0] m);
    logic signed [11:0] sh;
    logic signed [11:0] re;
    logic [47:0]        ms;
    logic               stk;
    logic [23:0]        keep;
    logic               up;
    logic [24:0]        sum;
    logic [31:0]        res;
    sh = 12'sd0;
    re = 12'sd0;
    ms = m;
    stk = 1'b0;
    if (r <= 12'sd0) begin
      // subnormal result: denormalize with sticky
      sh = 12'sd1 - r;
      if (sh > 12'sd48) begin
        ms = '0;
        stk = |m;
      end else begin
        ms = m >> sh[5:0];
        stk = |(m & ~({48{1'b1}} << sh[5:0]));
      end
      keep = ms[47:24];
      up = ms[23] & ((|ms[22:0]) | stk | keep[0]);
      sum = {1'b0, keep} + {24'd0, up};
      res = {sign, 7'd0, sum[23], sum[22:0]};
    end else begin
      keep = m[47:24];
      up = m[23] & ((|m[22:0]) | keep[0]);
      sum = {1'b0, keep} + {24'd0, up};
      re = r + $signed({11'd0, sum[24]});
      if (re >= 12'sd255) begin
        res = {sign, EXP_MAX, 23'd0};
      end else begin
        res = {sign, re[7:0], sum[22:0]};
      end
    end
    return res;
  endfunction

  // exact fp16 to fp32 widening
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [10:0] mn;
    logic [3:0]  shifts;
    logic        found;
    logic [31:0] res;
    ex = h[14:10];
    man = h[9:0];
    shifts = 4'd0;
    found = 1'b0;
    mn = {1'b0, man};
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        res = {h[15], 31'd0};
      end else begin
        // leading one position picks the normalizing shift
        for (int i = 9; i >= 0; i--) begin
          if (!found && man[i]) begin
            shifts = 4'(10 - i);
            found = 1'b1;
          end
        end
        mn = {1'b0, man} << shifts;
        res = {h[15], 8'd113 - {4'd0, shifts}, mn[9:0], 13'd0};
      end
    end else if (ex == 5'h1F) begin
      res = {h[15], EXP_MAX, man, 13'd0};
    end else begin
      res = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return res;
  endfunction

  // int4 code minus 8 as fp32
  function automatic logic [31:0] code_to_fp32(input logic [3:0] c);
    logic [31:0] res;
    case (c)
      4'd0:    res = 32'hC1000000;
      4'd1:    res = 32'hC0E00000;
      4'd2:    res = 32'hC0C00000;
      4'd3:    res = 32'hC0A00000;
      4'd4:    res = 32'hC0800000;
      4'd5:    res = 32'hC0400000;
      4'd6:    res = 32'hC0000000;
      4'd7:    res = 32'hBF800000;
      4'd8:    res = 32'h00000000;
      4'd9:    res = 32'h3F800000;
      4'd10:   res = 32'h40000000;
      4'd11:   res = 32'h40400000;
      4'd12:   res = 32'h40800000;
      4'd13:   res = 32'h40A00000;
      4'd14:   res = 32'h40C00000;
      4'd15:   res = 32'h40E00000;
      default: res = 32'h00000000;
    endcase
    return res;
  endfunction

endpackage

### design/i4dq_ctrl.sv
// Controller state machine for the int4 dequant dot product.
// Depends on i4dq_pkg and the block's assertion macro header.
`timescale 1ns / 1ps
`include "int4_dequant_dot_product_top_macros.svh"

module i4dq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i4dq_pkg::status_t st,
  output i4dq_pkg::cmd_t    cmd
);

  i4dq_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i4dq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i4dq_pkg::ST_IDLE:  if (in_valid) state_nxt = i4dq_pkg::ST_MUL1;
      i4dq_pkg::ST_MUL1:  state_nxt = i4dq_pkg::ST_MUL2;
      i4dq_pkg::ST_MUL2:  state_nxt = i4dq_pkg::ST_ADD1;
      i4dq_pkg::ST_ADD1:  state_nxt = i4dq_pkg::ST_ADD2;
      i4dq_pkg::ST_ADD2: begin
        state_nxt = st.last ? i4dq_pkg::ST_SMUL1 : i4dq_pkg::ST_IDLE;
      end
      i4dq_pkg::ST_SMUL1: state_nxt = i4dq_pkg::ST_SMUL2;
      i4dq_pkg::ST_SMUL2: if (!st.out_blocked) state_nxt = i4dq_pkg::ST_IDLE;
      default:            state_nxt = i4dq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      i4dq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap = in_valid;
      end
      i4dq_pkg::ST_MUL1:  cmd.mul1 = 1'b1;
      i4dq_pkg::ST_MUL2:  cmd.mul2 = 1'b1;
      i4dq_pkg::ST_ADD1:  cmd.add1 = 1'b1;
      i4dq_pkg::ST_ADD2:  cmd.add2 = 1'b1;
      i4dq_pkg::ST_SMUL1: begin
        cmd.mul1 = 1'b1;
        cmd.mul_scale = 1'b1;
      end
      i4dq_pkg::ST_SMUL2: begin
        cmd.out_load = !st.out_blocked;
        cmd.acc_clear = !st.out_blocked;
      end
      default: in_stall = 1'b1;
    endcase
  end

  `I4DQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == i4dq_pkg::ST_IDLE, "not idle after reset")
  `I4DQ_ASSERT(a_accept_starts, cmd.cap |=> state_r == i4dq_pkg::ST_MUL1, "accept did not start multiply")
  `I4DQ_ASSERT(a_hold_blocked, (state_r == i4dq_pkg::ST_SMUL2 && st.out_blocked) |=> state_r == i4dq_pkg::ST_SMUL2, "left result stage while output blocked")

endmodule

### design/i4dq_datapath.sv
// Datapath: item capture, shared fp32 multiplier, fp32 accumulate adder, output register.
// Depends on i4dq_pkg and the block's assertion macro header.
`timescale 1ns / 1ps
`include "int4_dequant_dot_product_top_macros.svh"

module i4dq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       in_act_bits,
  input  logic [7:0]        in_weight_byte,
  input  logic [15:0]       in_scale_bits,
  input  logic              in_last_element,
  input  i4dq_pkg::cmd_t    cmd,
  output i4dq_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_result_bits
);

  // captured item
  logic [31:0] act_r, w32_r, scale32_r;
  logic        last_r, odd_r;
  logic [31:0] acc_r, prod_r;
  // multiplier stage
  logic               m_spec_r;
  logic [31:0]        m_spec_val_r;
  logic               m_sign_r;
  logic signed [11:0] m_exp_r;
  logic [47:0]        m_prod_r;
  // adder stage
  logic               a_spec_r;
  logic [31:0]        a_spec_val_r;
  logic               a_sign_r;
  logic               a_zsign_r;
  logic [7:0]         a_exp_r;
  logic [27:0]        a_sum_r;
  // output
  logic        out_valid_r;
  logic [31:0] out_bits_r;

  // item capture and position parity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r <= 1'b0;
    end else if (cmd.cap) begin
      odd_r <= in_last_element ? 1'b0 : ~odd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_act_bits;
      w32_r <= i4dq_pkg::code_to_fp32(odd_r ? in_weight_byte[7:4] : in_weight_byte[3:0]);
      scale32_r <= i4dq_pkg::half_to_single(in_scale_bits);
      last_r <= in_last_element;
    end
  end

  // multiplier, first step: specials, exponent sum, mantissa product
  logic [31:0] op_a, op_b;
  logic [7:0]  ea, eb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, m_sign;
  logic        m_spec;
  logic [31:0] m_spec_val;
  logic signed [11:0] m_exp;
  logic [47:0] m_prod;

  always_comb begin
    op_a = cmd.mul_scale ? acc_r : act_r;
    op_b = cmd.mul_scale ? scale32_r : w32_r;
    nan_a = (op_a[30:23] == i4dq_pkg::EXP_MAX) && (op_a[22:0] != 23'd0);
    nan_b = (op_b[30:23] == i4dq_pkg::EXP_MAX) && (op_b[22:0] != 23'd0);
    inf_a = (op_a[30:23] == i4dq_pkg::EXP_MAX) && (op_a[22:0] == 23'd0);
    inf_b = (op_b[30:23] == i4dq_pkg::EXP_MAX) && (op_b[22:0] == 23'd0);
    zero_a = (op_a[30:0] == 31'd0);
    zero_b = (op_b[30:0] == 31'd0);
    m_sign = op_a[31] ^ op_b[31];
    ea = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
    eb = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
    m_exp = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
    m_prod = {24'd0, (op_a[30:23] != 8'd0), op_a[22:0]} *
             {24'd0, (op_b[30:23] != 8'd0), op_b[22:0]};
    m_spec = 1'b1;
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      m_spec_val = i4dq_pkg::CANON_NAN;
    end else if (inf_a || inf_b) begin
      m_spec_val = {m_sign, i4dq_pkg::EXP_MAX, 23'd0};
    end else if (zero_a || zero_b) begin
      m_spec_val = {m_sign, 31'd0};
    end else begin
      m_spec = 1'b0;
      m_spec_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      m_spec_r <= m_spec;
      m_spec_val_r <= m_spec_val;
      m_sign_r <= m_sign;
      m_exp_r <= m_exp;
      m_prod_r <= m_prod;
    end
  end

  // multiplier, second step: normalize and round
  logic [5:0]  m_lz;
  logic [31:0] mul_res;

  always_comb begin
    m_lz = i4dq_pkg::lzc48(m_prod_r);
    mul_res = m_spec_r ? m_spec_val_r :
              i4dq_pkg::round_pack(m_sign_r, m_exp_r - $signed({6'd0, m_lz}),
                                   m_prod_r << m_lz);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      prod_r <= mul_res;
    end
  end

  // adder, first step: specials, order by magnitude, align, add
  logic [31:0] big, sml;
  logic [7:0]  eg, es, d;
  logic [26:0] mg, msh, mal;
  logic        stk;
  logic        nan_x, nan_y, inf_x, inf_y;
  logic        a_spec;
  logic [31:0] a_spec_val;
  logic [27:0] a_sum;

  always_comb begin
    if (acc_r[30:0] >= prod_r[30:0]) begin
      big = acc_r;
      sml = prod_r;
    end else begin
      big = prod_r;
      sml = acc_r;
    end
    eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = eg - es;
    mg = {(big[30:23] != 8'd0), big[22:0], 3'd0};
    msh = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
    if (d >= 8'd27) begin
      mal = '0;
      stk = |msh;
    end else begin
      mal = msh >> d[4:0];
      stk = |(msh & ~({27{1'b1}} << d[4:0]));
    end
    mal[0] = mal[0] | stk;
    if (big[31] == sml[31]) begin
      a_sum = {1'b0, mg} + {1'b0, mal};
    end else begin
      a_sum = {1'b0, mg} - {1'b0, mal};
    end
    nan_x = (acc_r[30:23] == i4dq_pkg::EXP_MAX) && (acc_r[22:0] != 23'd0);
    nan_y = (prod_r[30:23] == i4dq_pkg::EXP_MAX) && (prod_r[22:0] != 23'd0);
    inf_x = (acc_r[30:23] == i4dq_pkg::EXP_MAX) && (acc_r[22:0] == 23'd0);
    inf_y = (prod_r[30:23] == i4dq_pkg::EXP_MAX) && (prod_r[22:0] == 23'd0);
    a_spec = 1'b1;
    if (nan_x || nan_y || (inf_x && inf_y && (acc_r[31] != prod_r[31]))) begin
      a_spec_val = i4dq_pkg::CANON_NAN;
    end else if (inf_x) begin
      a_spec_val = acc_r;
    end else if (inf_y) begin
      a_spec_val = prod_r;
    end else begin
      a_spec = 1'b0;
      a_spec_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add1) begin
      a_spec_r <= a_spec;
      a_spec_val_r <= a_spec_val;
      a_sign_r <= big[31];
      a_zsign_r <= acc_r[31] & prod_r[31];
      a_exp_r <= eg;
      a_sum_r <= a_sum;
    end
  end

  // adder, second step: normalize and round; exact zero is +0 unless both were -0
  logic [5:0]  a_lz;
  logic [47:0] a_wide;
  logic [31:0] add_res;

  always_comb begin
    a_wide = {a_sum_r, 20'd0};
    a_lz = i4dq_pkg::lzc48(a_wide);
    if (a_spec_r) begin
      add_res = a_spec_val_r;
    end else if (a_sum_r == 28'd0) begin
      add_res = {a_zsign_r, 31'd0};
    end else begin
      add_res = i4dq_pkg::round_pack(a_sign_r,
                  $signed({4'd0, a_exp_r}) + 12'sd1 - $signed({6'd0, a_lz}),
                  a_wide << a_lz);
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else if (cmd.acc_clear) begin
      acc_r <= 32'd0;
    end else if (cmd.add2) begin
      acc_r <= add_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bits_r <= mul_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_bits = out_bits_r;
  assign st.last = last_r;
  assign st.out_blocked = out_valid_r && out_stall;

  `I4DQ_ASSERT(a_no_overwrite, cmd.out_load |-> !(out_valid_r && out_stall), "result overwritten while stalled")
  `I4DQ_ASSERT(a_acc_cleared, cmd.acc_clear |=> acc_r == 32'd0, "accumulator not cleared")
  `I4DQ_ASSERT(a_parity_last, (cmd.cap && in_last_element) |=> !odd_r, "parity not reset by last item")

endmodule

### design/int4_dequant_dot_product_top.sv
// An item that is not last goes through the states MUL1, MUL2, ADD1 and ADD2 before
// the next accept. A last item then goes through SMUL1, which scales the sum, and
// SMUL2, which loads the output register when it is not stalled, before the next accept.
// The block takes no new item until it is through with the last one, due to the loop
// through the shared fp32 multiplier and the accumulate adder around the accumulator.
// Reset (synchronous, active low) clears the accumulator to +0, parity to even, no output.
`timescale 1ns / 1ps

module int4_dequant_dot_product_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_act_bits,
  input  logic [7:0]  in_weight_byte,
  input  logic [15:0] in_scale_bits,
  input  logic        in_last_element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);

  i4dq_pkg::cmd_t    cmd;
  i4dq_pkg::status_t st;

  // sequencer
  i4dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // arithmetic and storage
  i4dq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_act_bits     (in_act_bits),
    .in_weight_byte  (in_weight_byte),
    .in_scale_bits   (in_scale_bits),
    .in_last_element (in_last_element),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_bits (out_result_bits)
  );

endmodule

### verif/tb_int4_dequant_dot_product_top.sv
// Testbench for int4_dequant_dot_product_top: drives activation/weight items,
// predicts each scaled fp32 dot product with integer-exact fp32 arithmetic and
// checks every result. Depends on the RTL top only.
`timescale 1ns / 1ps

module tb_int4_dequant_dot_product_top;

  localparam logic [31:0] QNAN       = 32'h7FC00000;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          LONG_HOLD  = 300;

  typedef struct {
    logic [31:0] act;
    logic [7:0]  wbyte;
    logic [15:0] scale;
    logic        last;
  } elem_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_act_bits;
  logic [7:0]  in_weight_byte;
  logic [15:0] in_scale_bits;
  logic        in_last_element;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_bits;

  elem_t       pending_elems[$];
  logic [31:0] expected_dots[$];
  logic [31:0] acc_bits;
  logic        odd_pos;
  int          err_count;
  int          send_gap;
  int          recv_hold;
  int          idle_cycles;
  bit          no_idle;
  bit          long_hold_req;
  bit          long_hold_done;

  int4_dequant_dot_product_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_act_bits     (in_act_bits),
    .in_weight_byte  (in_weight_byte),
    .in_scale_bits   (in_scale_bits),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_bits (out_result_bits)
  );

  always #6 clk = ~clk;

  // ---------------- fp32 arithmetic on integers ----------------

  function automatic bit is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic bit is_inf(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  // round sign * m * 2^e to fp32, nearest even, subnormals kept
  function automatic logic [31:0] fp32_round(input logic sgn, input logic [65:0] m,
                                             input int e);
    int          p;
    int          sh;
    int          be;
    logic [65:0] q;
    logic [65:0] rem;
    logic [65:0] half;
    logic        up;
    if (m == 66'd0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 66; i++) if (m[i]) p = i;
    if (p + e + 127 >= 1) sh = p - 23;
    else sh = -149 - e;
    up = 1'b0;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh > 66) begin
      q = '0;
    end else begin
      q = m >> sh;
      rem = m & ((66'd1 << sh) - 66'd1);
      half = 66'd1 << (sh - 1);
      up = (rem > half) || (rem == half && q[0]);
    end
    q = q + up;
    if (q[24]) begin
      q = q >> 1;
      sh++;
    end
    if (q[23]) begin
      be = e + sh + 23 + 127;
      if (be >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, be[7:0], q[22:0]};
    end
    return {sgn, 8'd0, q[22:0]};
  endfunction

  function automatic void fp32_split(input logic [31:0] b, output logic [65:0] m,
                                     output int e);
    if (b[30:23] == 8'd0) begin
      m = {43'd0, b[22:0]};
      e = -149;
    end else begin
      m = {42'd0, 1'b1, b[22:0]};
      e = int'(b[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [65:0] ma;
    logic [65:0] mb;
    int          ea;
    int          eb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return QNAN;
      return {s, 8'hFF, 23'd0};
    end
    fp32_split(a, ma, ea);
    fp32_split(b, mb, eb);
    return fp32_round(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [65:0] ma;
    logic [65:0] mb;
    logic [65:0] xa;
    logic [65:0] xb;
    logic [65:0] full;
    logic [65:0] r;
    logic        s;
    int          ea;
    int          eb;
    int          d;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (b[30:0] > a[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    fp32_split(a, ma, ea);
    fp32_split(b, mb, eb);
    d = ea - eb;
    xa = ma << 40;
    full = mb << 40;
    // smaller operand aligned, bits shifted out folded into a sticky bit
    if (d >= 66) xb = {65'd0, |full};
    else xb = (full >> d) | {65'd0, |(full & ((66'd1 << d) - 66'd1))};
    if (a[31] == b[31]) begin
      r = xa + xb;
      s = a[31];
    end else begin
      r = xa - xb;
      s = a[31];
      if (r == 66'd0) return 32'd0;
    end
    return fp32_round(s, r, ea - 40);
  endfunction

  // exact fp16 to fp32
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) return {h[15], 31'd0};
      return fp32_round(h[15], {56'd0, h[9:0]}, -24);
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return fp32_round(h[15], {55'd0, 1'b1, h[9:0]}, int'(h[14:10]) - 25);
  endfunction

  // accumulate one accepted item, queue the scaled sum on the last one
  task automatic accumulate_elem(input elem_t it);
    logic [3:0]  code;
    int          w;
    logic [31:0] wbits;
    code = odd_pos ? it.wbyte[7:4] : it.wbyte[3:0];
    w = int'(code) - 8;
    wbits = fp32_round(w < 0, (w < 0) ? 66'(-w) : 66'(w), 0);
    acc_bits = fp32_add(acc_bits, fp32_mul(it.act, wbits));
    odd_pos = ~odd_pos;
    if (it.last) begin
      expected_dots.push_back(fp32_mul(acc_bits, widen_half(it.scale)));
      acc_bits = 32'd0;
      odd_pos = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) accumulate_elem('{in_act_bits, in_weight_byte, in_scale_bits,
                                      in_last_element});
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        in_act_bits     <= pending_elems[0].act;
        in_weight_byte  <= pending_elems[0].wbyte;
        in_scale_bits   <= pending_elems[0].scale;
        in_last_element <= pending_elems[0].last;
        void'(pending_elems.pop_front());
        in_valid <= 1'b1;
        send_gap <= no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    int hold;
    hold = recv_hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dots.size() == 0) begin
          report_mismatch("unexpected result", out_result_bits, 32'd0);
        end else begin
          if (out_result_bits !== expected_dots[0])
            report_mismatch("result_bits", out_result_bits, expected_dots[0]);
          void'(expected_dots.pop_front());
        end
        hold = no_idle ? 0 : $urandom_range(0, 4);
        if (long_hold_req && !long_hold_done) begin
          hold = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end else if (hold > 0) begin
        hold--;
      end
      recv_hold <= hold;
      out_stall <= (hold > 0);
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL int4_dequant_dot_product_top");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [31:0] pick_act();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      3: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom())};
      4: return {$urandom_range(0, 1) == 1, 8'($urandom_range(250, 254)), 23'($urandom())};
      5: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 4)), 23'($urandom())};
      6: return $urandom();
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)),
                       23'($urandom())};
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return {$urandom_range(0, 1) == 1, 15'd0};
      1: return {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom_range(1, 1023))};
      2: return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom())};
      3: return 16'($urandom());
      default: return {$urandom_range(0, 1) == 1, 5'($urandom_range(10, 20)),
                       10'($urandom())};
    endcase
  endfunction

  // well-formed dot products of random length, with some loose noise items
  task automatic queue_random(input int n);
    int len;
    while (n > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_elems.push_back('{$urandom(), 8'($urandom()), 16'($urandom()),
                                  1'($urandom())});
        n--;
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          pending_elems.push_back('{pick_act(), 8'($urandom()), pick_scale(), i == len - 1});
        n -= len;
      end
    end
  endtask

  task automatic drain();
    wait (pending_elems.size() == 0 && !in_valid && expected_dots.size() == 0);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_act_bits = '0;
    in_weight_byte = '0;
    in_scale_bits = '0;
    in_last_element = 1'b0;
    out_stall = 1'b0;
    acc_bits = 32'd0;
    odd_pos = 1'b0;
    err_count = 0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zeros, signed zero, scale edge cases
    pending_elems.push_back('{32'h00000000, 8'h00, 16'h3C00, 1'b1});
    pending_elems.push_back('{32'h80000000, 8'h88, 16'h8000, 1'b1});
    pending_elems.push_back('{32'h3F800000, 8'hF0, 16'h0001, 1'b0});
    pending_elems.push_back('{32'hBF800000, 8'hF0, 16'h03FF, 1'b1});
    // overflow to infinity, finite max scale
    pending_elems.push_back('{32'h7F7FFFFF, 8'h00, 16'h7BFF, 1'b1});
    pending_elems.push_back('{32'hFFFFFFFF, 8'hFF, 16'hFFFF, 1'b1});
    // infinity minus infinity gives NaN
    pending_elems.push_back('{32'h7F800000, 8'hFF, 16'h3C00, 1'b0});
    pending_elems.push_back('{32'hFF800000, 8'hFF, 16'h3C00, 1'b1});
    // zero scale, infinite scales (one against a zero sum), NaN scale
    pending_elems.push_back('{32'h3F800000, 8'h0F, 16'h0000, 1'b1});
    pending_elems.push_back('{32'h3F800000, 8'h0F, 16'h7C00, 1'b1});
    pending_elems.push_back('{32'h00000000, 8'h08, 16'hFC00, 1'b1});
    pending_elems.push_back('{32'h3F800000, 8'h0F, 16'h7E00, 1'b1});
    // subnormals, underflow and exact cancellation
    pending_elems.push_back('{32'h00000001, 8'h09, 16'h0001, 1'b0});
    pending_elems.push_back('{32'h80000001, 8'h90, 16'h3C00, 1'b1});
    pending_elems.push_back('{32'h007FFFFF, 8'hF0, 16'h0200, 1'b1});
    pending_elems.push_back('{32'h4B800001, 8'h00, 16'h3C00, 1'b0});
    pending_elems.push_back('{32'h3F800000, 8'hF0, 16'h3C00, 1'b0});
    pending_elems.push_back('{32'h7FFFFFFF, 8'h55, 16'h3C00, 1'b1});
    drain();

    // random, with one long receiver hold-off to fill the block
    long_hold_req = 1'b1;
    queue_random(200);
    drain();
    no_idle = 1'b1;
    queue_random(100);
    drain();
    no_idle = 1'b0;
    queue_random(200);
    drain();

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS int4_dequant_dot_product_top");
    end else begin
      $display("FAIL int4_dequant_dot_product_top");
    end
    $finish;
  end

endmodule
